### src/ppid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared widths, register indexes, reset values and the symmetric clamp used
// by the positional PID core.
// ----------------------------------------------------------------------------
package ppid_pkg;

  // Field widths
  localparam int InW      = 16;  // measured / target
  localparam int GainW    = 16;  // Q8.8 gains
  localparam int LimW     = 23;  // magnitude limits
  localparam int ErrW     = 17;  // target - measured
  localparam int DerrW    = 18;  // error - previous error
  localparam int IntW     = 24;  // integral accumulator
  localparam int DriveW   = 24;  // clamped output
  localparam int AccW     = 36;  // working width for sums before clamping
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 23;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_INT_LIMIT = 3'd3,
    CFG_OUT_LIMIT = 3'd4
  } cfg_idx_e;

  // Reset values
  localparam logic signed [GainW-1:0] GainPRst  = 16'sd256;
  localparam logic signed [GainW-1:0] GainIRst  = 16'sd26;
  localparam logic signed [GainW-1:0] GainDRst  = 16'sd26;
  localparam logic        [LimW-1:0]  IntLimRst = 23'd128000;
  localparam logic        [LimW-1:0]  OutLimRst = 23'd12800;

  // Clamp v to [-lim, +lim]
  function automatic logic signed [AccW-1:0] clamp_sym(
    input logic signed [AccW-1:0] v,
    input logic        [LimW-1:0] lim
  );
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = $signed(AccW'(lim));
    lo = -hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

### src/positional_pid_antiwindup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_pid_antiwindup_core
// Positional PID step with a clamped, sign-checked integral and a clamped
// output. One sample in, one drive value out.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Direction
//  -------   -----------------------------------  ---------
//  in        in_valid_i, in_stall_o, measured_i,   sample in
//            target_i
//  out       out_valid_o, out_stall_i, drive_o     drive out
//  cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i      register write
//
//  A sample enters an input register holding the error, then one pass of
//  three 16x17/18 multiplies, adds and clamps writes the result register.
//  A new transaction is taken every cycle while the output is not stalled.
//  The integral and previous error update in the same cycle the result is
//  registered, so back-to-back samples see fresh state.
//  Reset clears the integral and previous error and restores the gains.
//  A stall on the output holds the result and backs up into in_stall_o.
// ----------------------------------------------------------------------------
module positional_pid_antiwindup_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [ppid_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ppid_pkg::CfgDataW-1:0]        cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ppid_pkg::InW-1:0]      measured_i,
  input  logic signed [ppid_pkg::InW-1:0]      target_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ppid_pkg::DriveW-1:0]   drive_o
);
  import ppid_pkg::*;

  // Configuration registers
  logic signed [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic        [LimW-1:0]  int_lim_q, out_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= GainPRst;
      gain_i_q  <= GainIRst;
      gain_d_q  <= GainDRst;
      int_lim_q <= IntLimRst;
      out_lim_q <= OutLimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_P:    gain_p_q  <= cfg_wdata_i[GainW-1:0];
        CFG_GAIN_I:    gain_i_q  <= cfg_wdata_i[GainW-1:0];
        CFG_GAIN_D:    gain_d_q  <= cfg_wdata_i[GainW-1:0];
        CFG_INT_LIMIT: int_lim_q <= cfg_wdata_i[LimW-1:0];
        CFG_OUT_LIMIT: out_lim_q <= cfg_wdata_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  logic s1_valid_q;
  logic out_valid_q;
  logic advance;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  // Input register: error formed on entry
  logic signed [ErrW-1:0] s1_err_d, s1_err_q;
  assign s1_err_d = {target_i[InW-1], target_i} - {measured_i[InW-1], measured_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_err_q <= s1_err_d;
    end
  end

  // Controller state
  logic signed [IntW-1:0] integ_q, integ_d;
  logic signed [ErrW-1:0] prev_err_q;

  // Products
  logic signed [DerrW-1:0]       derr;
  logic signed [GainW+ErrW-1:0]  p_prod, i_prod;
  logic signed [GainW+DerrW-1:0] d_prod;

  assign derr   = DerrW'(s1_err_q) - DerrW'(prev_err_q);
  assign p_prod = (GainW+ErrW)'(gain_p_q) * (GainW+ErrW)'(s1_err_q);
  assign i_prod = (GainW+ErrW)'(gain_i_q) * (GainW+ErrW)'(s1_err_q);
  assign d_prod = (GainW+DerrW)'(gain_d_q) * (GainW+DerrW)'(derr);

  // Integral: accumulate, clamp, then clear on opposite sign
  logic signed [AccW-1:0] acc_sum, acc_clamp;
  logic                   sign_clash;

  assign acc_sum    = AccW'(integ_q) + AccW'(i_prod);
  assign acc_clamp  = clamp_sym(acc_sum, int_lim_q);
  assign sign_clash = (acc_clamp > 0 && s1_err_q < 0) || (acc_clamp < 0 && s1_err_q > 0);
  assign integ_d    = sign_clash ? '0 : IntW'(acc_clamp);

  // Output sum and clamp
  logic signed [AccW-1:0]   drv_sum, drv_clamp;
  logic signed [DriveW-1:0] drive_d, drive_q;

  assign drv_sum   = AccW'(p_prod) + AccW'(d_prod) + AccW'(integ_d);
  assign drv_clamp = clamp_sym(drv_sum, out_lim_q);
  assign drive_d   = DriveW'(drv_clamp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      prev_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      integ_q     <= integ_d;
      prev_err_q  <= s1_err_q;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // Assertions
  a_drive_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_o <= $signed({1'b0, out_lim_q}) &&
                     drive_o >= -$signed({1'b0, out_lim_q})))
    else $error("drive outside output limit");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_o && prev_err_q == $past(s1_err_q)))
    else $error("result or previous error not updated");

  a_integ_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_err_q > 0) |=> integ_q >= 0)
    else $error("integral sign disagrees with positive error");

endmodule

### test/positional_pid_antiwindup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_pid_antiwindup_core_tb
// Self-checking bench for the positional PID core. Samples go in over the
// valid/stall channel with random gaps, and drive values are taken out with
// random stalls. A bit-accurate model of the controller keeps its own gains,
// limits, integral and previous error, and computes the drive value for each
// accepted sample. The run starts with directed corner cases: full-scale
// errors, extreme gains, zero and maximum limits, integral clearing on a
// sign flip and an unknown register index. It then runs random phases, each
// with fresh register settings, made mostly of setpoint tracking with biased
// errors plus full-range noise.
// ----------------------------------------------------------------------------
module positional_pid_antiwindup_core_tb;
  import ppid_pkg::*;

  localparam int          ClkPeriod   = 10;
  localparam int          ResetCycles = 10;
  localparam int          DrainCycles = 4;
  localparam int unsigned LimitCycles = 200000;
  localparam int          NumPhases   = 11;
  localparam int          PhaseLen    = 50;
  localparam int          MaxWait     = 5;
  localparam int          InMax       = 32767;
  localparam int          InMin       = -32768;

  // --------------------------------------------------------------------------
  // Controller model and store of pending drive values
  // --------------------------------------------------------------------------
  class pid_drive_predictor;
    logic signed [GainW-1:0]  kp;
    logic signed [GainW-1:0]  ki;
    logic signed [GainW-1:0]  kd;
    logic        [LimW-1:0]   int_lim;
    logic        [LimW-1:0]   out_lim;
    logic signed [IntW-1:0]   integ;
    logic signed [ErrW-1:0]   last_err;
    logic signed [DriveW-1:0] drive_due_q[$];
    int unsigned              mismatches;

    function new();
      kp         = GainPRst;
      ki         = GainIRst;
      kd         = GainDRst;
      int_lim    = IntLimRst;
      out_lim    = OutLimRst;
      integ      = '0;
      last_err   = '0;
      mismatches = 0;
    endfunction

    // Register write; unknown indexes fall through untouched
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_GAIN_P:    kp = data[GainW-1:0];
        CFG_GAIN_I:    ki = data[GainW-1:0];
        CFG_GAIN_D:    kd = data[GainW-1:0];
        CFG_INT_LIMIT: int_lim = data[LimW-1:0];
        CFG_OUT_LIMIT: out_lim = data[LimW-1:0];
        default: ;
      endcase
    endfunction

    // Symmetric saturation to +/- lim
    function logic signed [AccW-1:0] saturate(logic signed [AccW-1:0] v,
                                              logic [LimW-1:0] lim);
      logic signed [AccW-1:0] bound;
      bound = $signed({{(AccW-LimW){1'b0}}, lim});
      if (v > bound) return bound;
      if (v < -bound) return -bound;
      return v;
    endfunction

    function int pending();
      return drive_due_q.size();
    endfunction

    // One controller step for an accepted sample
    function void accept_sample(logic signed [InW-1:0] measured,
                                logic signed [InW-1:0] target);
      logic signed [ErrW-1:0] m_w;
      logic signed [ErrW-1:0] t_w;
      logic signed [ErrW-1:0] err;
      logic signed [AccW-1:0] err_w;
      logic signed [AccW-1:0] prev_w;
      logic signed [AccW-1:0] kp_w;
      logic signed [AccW-1:0] ki_w;
      logic signed [AccW-1:0] kd_w;
      logic signed [AccW-1:0] acc;
      logic signed [AccW-1:0] drive_w;
      m_w    = ErrW'(measured);
      t_w    = ErrW'(target);
      err    = t_w - m_w;
      err_w  = AccW'(err);
      prev_w = AccW'(last_err);
      kp_w   = AccW'(kp);
      ki_w   = AccW'(ki);
      kd_w   = AccW'(kd);
      acc    = AccW'(integ);

      // integral: accumulate, clamp, then clear on opposite signs
      acc = saturate(acc + ki_w * err_w, int_lim);
      if ((acc > 0 && err < 0) || (acc < 0 && err > 0)) acc = '0;
      integ = acc[IntW-1:0];

      drive_w = kp_w * err_w + kd_w * (err_w - prev_w) + acc;
      drive_w = saturate(drive_w, out_lim);
      drive_due_q.push_back(drive_w[DriveW-1:0]);
      last_err = err;
    endfunction

    // Compare a delivered drive value with the oldest pending one
    function void check_drive(logic signed [DriveW-1:0] actual);
      logic signed [DriveW-1:0] due;
      if (drive_due_q.size() == 0) begin
        $error("drive %0d delivered with no sample pending", actual);
        mismatches++;
        return;
      end
      due = drive_due_q.pop_front();
      if (actual !== due) begin
        $error("drive mismatch: expected %0d, actual %0d", due, actual);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CfgDataW-1:0]      cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [InW-1:0]    measured_i;
  logic signed [InW-1:0]    target_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DriveW-1:0] drive_o;

  pid_drive_predictor pid_model = new();
  bit                 no_idle   = 1'b0;
  int unsigned        cycle_count = 0;

  positional_pid_antiwindup_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .measured_i  (measured_i),
    .target_i    (target_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $error("timeout after %0d cycles, %0d drive values pending",
             cycle_count, pid_model.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, MaxWait);
  endfunction

  function automatic logic signed [GainW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return GainW'(InMin);
      1:       return GainW'(InMax);
      2:       return GainW'($urandom_range(0, 600));
      3:       return -GainW'($urandom_range(0, 600));
      default: return GainW'($urandom);
    endcase
  endfunction

  function automatic logic [LimW-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return LimW'($urandom_range(1, 20000));
      3:       return LimW'($urandom_range(20000, 500000));
      default: return LimW'($urandom);
    endcase
  endfunction

  // One register write; the caller lowers the write enable after a burst
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    pid_model.write_reg(idx, data);
  endtask

  // Gains carry random junk in the unused upper bits of the write data
  task automatic configure(logic signed [GainW-1:0] kp, logic signed [GainW-1:0] ki,
                           logic signed [GainW-1:0] kd, logic [LimW-1:0] ilim,
                           logic [LimW-1:0] olim);
    logic [CfgDataW-1:0] data;
    data = CfgDataW'($urandom);
    data[GainW-1:0] = kp;
    write_reg(CFG_GAIN_P, data);
    data = CfgDataW'($urandom);
    data[GainW-1:0] = ki;
    write_reg(CFG_GAIN_I, data);
    data = CfgDataW'($urandom);
    data[GainW-1:0] = kd;
    write_reg(CFG_GAIN_D, data);
    write_reg(CFG_INT_LIMIT, ilim);
    write_reg(CFG_OUT_LIMIT, olim);
    cfg_we_i <= 1'b0;
  endtask

  // Write to an index past the last register; must have no effect
  task automatic write_unused_reg();
    write_reg(CfgIdxW'($urandom_range(CFG_OUT_LIMIT + 1, (1 << CfgIdxW) - 1)),
              CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Input transaction: optional gap, then hold until accepted
  task automatic send_sample(logic signed [InW-1:0] m, logic signed [InW-1:0] t);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_i <= m;
    target_i   <= t;
    do @(posedge clk_i); while (in_stall_o);
    pid_model.accept_sample(m, t);
  endtask

  // Sample around a setpoint with the given error, saturated to the input range
  task automatic send_tracking(int setpoint, int err);
    int m;
    m = setpoint - err;
    if (m > InMax) m = InMax;
    else if (m < InMin) m = InMin;
    send_sample(InW'(m), InW'(setpoint));
  endtask

  // Block is idle once every drive value is back and the pipe has drained
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pid_model.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall, then take one transaction
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      hold = draw_wait();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      pid_model.check_drive(drive_o);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int setpoint;
    int sgn;
    int err;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_GAIN_P;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    measured_i  <= '0;
    target_i    <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gains: full-scale errors, zero error holds the integral,
    // integral cleared when the error flips sign
    send_sample(0, 0);
    send_sample(InW'(InMin), InW'(InMax));
    send_sample(InW'(InMin), InW'(InMax));
    send_sample(100, 100);
    send_sample(1, 0);
    send_sample(InW'(InMax), InW'(InMin));
    send_sample(InW'(InMax), InW'(InMin));
    send_sample(0, 1);
    send_sample(InW'(InMax), InW'(InMax));
    send_sample(InW'(InMin), InW'(InMin));
    wait_idle();

    // extreme gains, widest limits; unused index must not disturb anything
    configure(GainW'(InMax), GainW'(InMin), GainW'(InMax), '1, '1);
    write_unused_reg();
    send_sample(InW'(InMin), InW'(InMax));
    send_sample(InW'(InMax), InW'(InMin));
    send_sample(InW'(InMax), InW'(InMin));
    send_sample(0, 0);
    wait_idle();

    // zero limits force integral and drive to zero
    configure(GainW'(InMin), GainW'(InMax), GainW'(InMin), '0, '0);
    send_sample(InW'(InMin), InW'(InMax));
    send_sample(InW'(InMax), InW'(InMin));
    send_sample(-7, 9);
    wait_idle();

    // integral only: wind up into the clamp, then one step of opposite sign
    // clears it after clamping
    configure(0, 256, 0, 1000, '1);
    send_sample(0, 10);
    send_sample(0, 10);
    send_sample(0, 10);
    send_sample(1, 0);
    send_sample(0, 0);
    wait_idle();

    // random phases with fresh settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      configure(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
      if ($urandom_range(0, 3) == 0) write_unused_reg();
      setpoint = int'($signed(InW'($urandom)));
      sgn = $urandom_range(0, 1) ? 1 : -1;
      for (int k = 0; k < PhaseLen; k++) begin
        case ($urandom_range(0, 9)) inside
          0, 1: send_sample(InW'($urandom), InW'($urandom));
          2:    send_tracking(setpoint, -sgn * int'($urandom_range(0, 200)));
          default: begin
            err = sgn * int'($urandom_range(0, 3000));
            send_tracking(setpoint, err);
          end
        endcase
        // occasional setpoint move and bias reversal
        if ($urandom_range(0, 15) == 0) begin
          setpoint = int'($signed(InW'($urandom)));
          sgn = -sgn;
        end
      end
      wait_idle();
    end

    no_idle = 1'b0;
    if (pid_model.mismatches == 0 && pid_model.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
